[rtl/core/ascii_number_parser_unit_defines.svh]
// Assertion macros used by the parser's checker file.
`ifndef ASCII_NUMBER_PARSER_UNIT_DEFINES_SVH
`define ASCII_NUMBER_PARSER_UNIT_DEFINES_SVH

// Check that cons holds in the cycle after ante, outside reset.
`define ANP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ascii_number_parser_unit: check failed");

// Check that cons holds in the same cycle as ante, outside reset.
`define ANP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ascii_number_parser_unit: check failed");

// Check that cons holds whenever ante holds, reset included.
`define ANP_ASSERT_ALWAYS(label, clk, ante, cons) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("ascii_number_parser_unit: check failed");

`endif

[rtl/core/anp_pkg.sv]
// Shared types and constants of the ASCII number parser.
`default_nettype none

package anp_pkg;

	// Default accumulator width and queue depths
	localparam int VALUE_WIDTH = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int RESULT_DEPTH = 2;

	// Character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] LC_BIAS  = 8'd87;
	localparam logic [7:0] UC_BIAS  = 8'd55;

	// Operation codes passed from front to back
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_DIGIT = 2'd2;
	localparam logic [1:0] OP_BAD   = 2'd3;

	// Character position codes
	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_LATER  = 2'd2;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} anp_in_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               bad_char;
	} anp_out_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] digit;
		logic       hex;
		logic       neg;
		logic       last;
	} anp_op_t;

endpackage

`default_nettype wire

[rtl/core/anp_fifo.sv]
// Small register queue with count-based full and empty flags.
`default_nettype none

module anp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/anp_front.sv]
// Front end: tracks string position and prefix, classifies each character.
`default_nettype none

module anp_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire anp_pkg::anp_in_t item,
	input  wire logic             accept,
	output anp_pkg::anp_op_t      op
);

	logic [1:0] pos_q;
	logic       fwz_q;
	logic       hex_q;
	logic       neg_q;
	logic       stop_q;

	logic       is_term;
	logic       is_dec;
	logic       is_lc;
	logic       is_uc;
	logic [7:0] dval;
	logic       take_sign;
	logic       take_prefix;
	logic       neg_nxt;

	// Decode the character
	always_comb begin
		is_term = (item.ch == anp_pkg::CH_SPACE) || (item.ch == anp_pkg::CH_CR);
		is_dec  = item.ch inside {[anp_pkg::CH_ZERO:anp_pkg::CH_NINE]};
		is_lc   = item.ch inside {[anp_pkg::CH_LC_A:anp_pkg::CH_LC_F]};
		is_uc   = item.ch inside {[anp_pkg::CH_UC_A:anp_pkg::CH_UC_F]};
		if (is_dec) begin
			dval = item.ch - anp_pkg::CH_ZERO;
		end else if (is_lc) begin
			dval = item.ch - anp_pkg::LC_BIAS;
		end else begin
			dval = item.ch - anp_pkg::UC_BIAS;
		end
	end

	// Pick the operation for the back end
	always_comb begin
		take_sign   = !stop_q && (pos_q == anp_pkg::POS_FIRST)
			&& (item.ch == anp_pkg::CH_MINUS);
		take_prefix = !stop_q && (pos_q == anp_pkg::POS_SECOND) && fwz_q
			&& (item.ch == anp_pkg::CH_X);
		neg_nxt     = neg_q || take_sign;

		op.digit = dval[3:0];
		op.hex   = hex_q;
		op.neg   = neg_nxt;
		op.last  = item.last;
		if (stop_q || take_sign || (!take_prefix && is_term)) begin
			op.kind = anp_pkg::OP_NONE;
		end else if (take_prefix) begin
			op.kind = anp_pkg::OP_CLEAR;
		end else if (is_dec || is_lc || is_uc) begin
			op.kind = anp_pkg::OP_DIGIT;
		end else begin
			op.kind = anp_pkg::OP_BAD;
		end
	end

	// Advance position and prefix state, drop it at the end of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= anp_pkg::POS_FIRST;
			fwz_q  <= 1'b0;
			hex_q  <= 1'b0;
			neg_q  <= 1'b0;
			stop_q <= 1'b0;
		end else if (accept) begin
			if (item.last) begin
				pos_q  <= anp_pkg::POS_FIRST;
				fwz_q  <= 1'b0;
				hex_q  <= 1'b0;
				neg_q  <= 1'b0;
				stop_q <= 1'b0;
			end else begin
				if (pos_q != anp_pkg::POS_LATER) begin
					pos_q <= pos_q + 1'b1;
				end
				if (!stop_q && (pos_q == anp_pkg::POS_FIRST) && !take_sign) begin
					fwz_q <= (item.ch == anp_pkg::CH_ZERO);
				end
				if (take_prefix) begin
					hex_q <= 1'b1;
				end
				neg_q <= neg_nxt;
				if (!stop_q && !take_sign && !take_prefix && is_term) begin
					stop_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/anp_back.sv]
// Back end: multiply-accumulate per operation and result queue.
`default_nettype none

module anp_back #(
	parameter int VALUE_WIDTH  = anp_pkg::VALUE_WIDTH,
	parameter int RESULT_DEPTH = anp_pkg::RESULT_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             op_valid,
	input  wire anp_pkg::anp_op_t op,
	output logic                  op_pop,
	output logic                  empty,
	input  wire logic             pop,
	output anp_pkg::anp_out_t     result
);

	logic [VALUE_WIDTH-1:0]    acc_q;
	logic                      err_q;
	logic [VALUE_WIDTH-1:0]    mul;
	logic [VALUE_WIDTH-1:0]    acc_nxt;
	logic [VALUE_WIDTH-1:0]    fin;
	logic [VALUE_WIDTH+31:0]   fin_ext;
	logic                      err_nxt;
	logic                      res_full;
	anp_pkg::anp_out_t         res_in;
	logic [$bits(anp_pkg::anp_out_t)-1:0] res_out;

	// Scale by the base with shifts and add the digit
	always_comb begin
		mul = op.hex ? (acc_q << 4) : ((acc_q << 3) + (acc_q << 1));
		acc_nxt = acc_q;
		err_nxt = err_q;
		case (op.kind)
			anp_pkg::OP_NONE:  acc_nxt = acc_q;
			anp_pkg::OP_CLEAR: acc_nxt = '0;
			anp_pkg::OP_DIGIT: acc_nxt = mul + VALUE_WIDTH'(op.digit);
			anp_pkg::OP_BAD: begin
				acc_nxt = mul;
				err_nxt = 1'b1;
			end
			default: acc_nxt = acc_q;
		endcase
		fin     = op.neg ? ('0 - acc_nxt) : acc_nxt;
		fin_ext = {32'b0, fin};
		res_in.value    = fin_ext[31:0];
		res_in.bad_char = err_nxt;
	end

	// Take an operation unless its result has nowhere to go
	assign op_pop = op_valid && (!op.last || !res_full);

	// Hold the accumulator, clear it after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			err_q <= 1'b0;
		end else if (op_pop) begin
			if (op.last) begin
				acc_q <= '0;
				err_q <= 1'b0;
			end else begin
				acc_q <= acc_nxt;
				err_q <= err_nxt;
			end
		end
	end

	anp_fifo #(
		.WIDTH($bits(anp_pkg::anp_out_t)),
		.DEPTH(RESULT_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (op_pop && op.last),
		.wr_data(res_in),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_out),
		.empty  (empty)
	);

	assign result = anp_pkg::anp_out_t'(res_out);

endmodule

`default_nettype wire

[rtl/core/ascii_number_parser_unit.sv]
// Top level of the ASCII number parser: front, operation queue, back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------
//  input    | push / full        | item.ch, item.last
//  result   | empty / pop        | result.value, result.bad_char
//
// One character is taken each cycle while full is low; the front classifies it in
// the cycle it is pushed, the back applies one multiply-accumulate per cycle while
// an operation waits and a last one has room for its result in the result queue.
// full rises only when the operation queue fills because results are not popped.
// arst_n clears all control state and both queues at once.
`default_nettype none

module ascii_number_parser_unit #(
	parameter int VALUE_WIDTH  = anp_pkg::VALUE_WIDTH,
	parameter int QUEUE_DEPTH  = anp_pkg::QUEUE_DEPTH,
	parameter int RESULT_DEPTH = anp_pkg::RESULT_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire anp_pkg::anp_in_t item,
	output logic                  empty,
	input  wire logic             pop,
	output anp_pkg::anp_out_t     result
);

	anp_pkg::anp_op_t                   fe_op;
	logic [$bits(anp_pkg::anp_op_t)-1:0] q_data;
	logic                               q_empty;
	logic                               be_pop;

	anp_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.accept(push && !full),
		.op    (fe_op)
	);

	anp_fifo #(
		.WIDTH($bits(anp_pkg::anp_op_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_op_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(fe_op),
		.full   (full),
		.rd_en  (be_pop),
		.rd_data(q_data),
		.empty  (q_empty)
	);

	anp_back #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.RESULT_DEPTH(RESULT_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.op_valid(!q_empty),
		.op      (anp_pkg::anp_op_t'(q_data)),
		.op_pop  (be_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

`default_nettype wire

[rtl/core/anp_checker.sv]
// Port-level checks on the parser, attached by bind.
`default_nettype none

`include "ascii_number_parser_unit_defines.svh"

module anp_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              push,
	input wire logic              full,
	input wire logic              empty,
	input wire logic              pop,
	input wire anp_pkg::anp_out_t result
);

	// A waiting result stays and holds its word until popped
	`ANP_ASSERT_NEXT(a_res_hold, clk, arst_n, !empty && !pop, !empty && $stable(result))

	// The queue fills only through an accepted word
	`ANP_ASSERT_NOW(a_full_rise, clk, arst_n, $rose(full), $past(push && !full))

	// Reset shows an empty result side and an open input
	`ANP_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n, empty && !full)

endmodule

bind ascii_number_parser_unit anp_checker u_anp_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.push  (push),
	.full  (full),
	.empty (empty),
	.pop   (pop),
	.result(result)
);

`default_nettype wire

[tb/ascii_number_parser_unit_tb.sv]
// Self-checking testbench for the ASCII number parser unit.
module ascii_number_parser_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import anp_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;

	logic clk = 1'b0;
	logic arst_n;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	anp_in_t item_word = '0;
	anp_out_t result;

	// Handshake state sampled mid-cycle, consumed at the next rising edge
	logic in_taken = 1'b0;
	logic out_taken = 1'b0;
	anp_out_t out_word = '0;

	// Parser state mirrored by the predictor
	logic [1:0] pos;
	logic zero_lead;
	logic hex_on;
	logic neg_on;
	logic halted;
	logic [VALUE_WIDTH-1:0] acc;
	logic err;

	anp_out_t pending_numbers[$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int unsigned hold_cycles = 0;
	logic sender_idle = 1'b1;
	logic receiver_idle = 1'b1;

	ascii_number_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item_word),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Sample both handshakes away from the active edge
	always @(negedge clk) begin
		in_taken = push && !full;
		out_taken = pop && !empty;
		out_word = result;
	end

	// Return the parser to the start of a string
	function automatic void clear_parse();
		pos = POS_FIRST;
		zero_lead = 1'b0;
		hex_on = 1'b0;
		neg_on = 1'b0;
		halted = 1'b0;
		acc = '0;
		err = 1'b0;
	endfunction

	// Fold one character into the accumulator, or stop on a terminator
	function automatic void fold_digit(logic [7:0] c);
		if (c == CH_SPACE || c == CH_CR) begin
			halted = 1'b1;
		end else begin
			acc = VALUE_WIDTH'(acc * (hex_on ? 16 : 10));
			if (c >= CH_ZERO && c <= CH_NINE) begin
				acc = acc + (c - CH_ZERO);
			end else if (c >= CH_LC_A && c <= CH_LC_F) begin
				acc = acc + (c - LC_BIAS);
			end else if (c >= CH_UC_A && c <= CH_UC_F) begin
				acc = acc + (c - UC_BIAS);
			end else begin
				err = 1'b1;
			end
		end
	endfunction

	// Advance the parser by one accepted word; queue the number on the last one
	function automatic void parse_char(logic [7:0] c, logic l);
		anp_out_t num;
		logic [VALUE_WIDTH-1:0] signed_acc;
		if (!halted) begin
			if (pos == POS_FIRST) begin
				if (c == CH_MINUS) begin
					neg_on = 1'b1;
				end else begin
					zero_lead = (c == CH_ZERO);
					fold_digit(c);
				end
			end else if (pos == POS_SECOND && zero_lead && c == CH_X) begin
				hex_on = 1'b1;
				acc = '0;
			end else begin
				fold_digit(c);
			end
		end
		if (pos != POS_LATER)
			pos = pos + 2'd1;
		if (l) begin
			signed_acc = neg_on ? -acc : acc;
			num.value = 32'(signed_acc);
			num.bad_char = err;
			pending_numbers.push_back(num);
			clear_parse();
		end
	endfunction

	function automatic void note_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch at %0t: %s", $realtime, msg);
	endfunction

	// Compare each popped word with the oldest predicted number
	always @(posedge clk) begin
		anp_out_t want;
		if (arst_n && out_taken) begin
			if (pending_numbers.size() == 0) begin
				note_mismatch($sformatf("unexpected result value %0d bad_char %0b",
					out_word.value, out_word.bad_char));
			end else begin
				want = pending_numbers.pop_front();
				if (out_word.value !== want.value)
					note_mismatch($sformatf("value expected %0d got %0d",
						want.value, out_word.value));
				if (out_word.bad_char !== want.bad_char)
					note_mismatch($sformatf("bad_char expected %0b got %0b",
						want.bad_char, out_word.bad_char));
			end
		end
	end

	// Abort when neither side moves a word for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_taken || out_taken)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Drive pop: long hold-offs on request, random stall bursts while receiver_idle is set
	initial begin
		int unsigned n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles != 0) begin
				n = hold_cycles;
				hold_cycles = 0;
				pop <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (receiver_idle && $urandom_range(0, 4) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offer one word, with an optional gap first, and hold it until accepted
	task automatic send_char(input logic [7:0] c, input logic l);
		if (sender_idle && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		push <= 1'b1;
		item_word <= '{ch: c, last: l};
		do @(posedge clk); while (!in_taken);
		parse_char(c, l);
	endtask

	task automatic send_text(input string t);
		for (int i = 0; i < t.len(); i++)
			send_char(t[i], i == t.len() - 1);
	endtask

	// Build one string: mostly well-formed numbers, some noise and damage
	task automatic send_random_string(output int count);
		logic [7:0] s[$];
		string hexset;
		int kind;
		int len;
		hexset = "0123456789abcdefABCDEF";
		kind = $urandom_range(0, 7);
		len = $urandom_range(1, 10);
		if (kind == 0) begin
			repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(0, 255)));
		end else begin
			if (kind <= 2) begin
				s.push_back(CH_MINUS);
			end else if (kind <= 4) begin
				s.push_back(CH_ZERO);
				s.push_back(CH_X);
			end
			repeat (len) begin
				if ($urandom_range(0, 3) == 0)
					s.push_back(hexset[$urandom_range(0, 21)]);
				else
					s.push_back(hexset[$urandom_range(0, 9)]);
			end
			if ($urandom_range(0, 9) == 0)
				s.insert($urandom_range(0, s.size()), 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 9) == 0) begin
				s.push_back($urandom_range(0, 1) ? CH_SPACE : CH_CR);
				repeat ($urandom_range(0, 3)) s.push_back(8'($urandom_range(0, 255)));
			end
		end
		for (int i = 0; i < s.size(); i++)
			send_char(s[i], i == s.size() - 1);
		count = s.size();
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pending_numbers.size() != 0);
	endtask

	// Special cases and field extremes
	task automatic test_directed();
		send_text("0x");
		send_text("-");
		send_text(" 1");
		send_text("8 ");
		send_char(8'h37, 1'b0);
		send_char(CH_CR, 1'b1);
		send_text("0");
		send_text("0xfF");
		send_text("-aZ");
		send_char(8'hff, 1'b1);
		send_char(8'h00, 1'b1);
		send_text("9999999999");
	endtask

	// Stall the receiver long enough for the input to back up
	task automatic test_backpressure();
		sender_idle = 1'b0;
		hold_cycles = 80;
		repeat (20) send_text("3");
		sender_idle = 1'b1;
	endtask

	// Stop sending until every predicted number has been popped
	task automatic test_drain_pause();
		int n;
		repeat (4) send_random_string(n);
		push <= 1'b0;
		wait_drained();
		repeat (4) send_random_string(n);
	endtask

	// Random strings with idling switched on and off in stretches
	task automatic test_random();
		int sent;
		int n;
		sent = 0;
		while (sent < 1100) begin
			if ($urandom_range(0, 15) == 0)
				sender_idle = $urandom_range(0, 1);
			if ($urandom_range(0, 15) == 0)
				receiver_idle = $urandom_range(0, 1);
			send_random_string(n);
			sent += n;
		end
	endtask

	// Closing stretch at full rate on both sides
	task automatic test_no_idle();
		int sent;
		int n;
		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		sent = 0;
		while (sent < 120) begin
			send_random_string(n);
			sent += n;
		end
	endtask

	initial begin
		clear_parse();
		// Assert reset with a real falling edge ahead of the first clock
		#1 arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_drain_pause();
		test_random();
		test_no_idle();
		push <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		if (pending_numbers.size() != 0)
			note_mismatch($sformatf("%0d numbers never arrived", pending_numbers.size()));
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/anp_pkg.sv
rtl/core/anp_fifo.sv
rtl/core/anp_front.sv
rtl/core/anp_back.sv
rtl/core/ascii_number_parser_unit.sv
rtl/core/anp_checker.sv
tb/ascii_number_parser_unit_tb.sv
